// ===== rtl/u8u16_pkg.sv =====
// Package with the shared types, codes and constants of the UTF-8 / UTF-16 transcoder.
`timescale 1ns / 1ps
package u8u16_pkg;

  // Register indexes on the configuration port.
  localparam logic REG_DIRECTION  = 1'b0;
  localparam logic REG_TERMINATOR = 1'b1;

  // Direction codes.
  localparam logic DIR_DECODE = 1'b0;
  localparam logic DIR_ENCODE = 1'b1;

  // Configuration port widths.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Character constants.
  localparam logic [15:0] REPL_CHAR   = 16'hFFFD;
  localparam logic [15:0] ENC_TWO_MIN = 16'h0080;
  localparam logic [15:0] ENC_THR_MIN = 16'h0800;
  localparam logic [7:0]  LEAD_TWO    = 8'hC0;
  localparam logic [7:0]  LEAD_THREE  = 8'hE0;
  localparam logic [7:0]  CONT_MARK   = 8'h80;

  // Number of words one input word can give at most.
  localparam int unsigned MAX_RES = 3;

  // Decode progress through a multi-byte sequence.
  typedef enum logic [1:0] {
    PEND_NONE   = 2'd0,
    PEND_TWO    = 2'd1,
    PEND_THREE  = 2'd2,
    PEND_SECOND = 2'd3
  } pend_e;

  // One result word before the framing flags are attached.
  typedef struct packed {
    logic [15:0] unit;
    logic        has_data;
  } result_t;

endpackage

// ===== rtl/u8u16_if.sv =====
// Stream interfaces for the input and result channels of the transcoder.
`timescale 1ns / 1ps
interface u8u16_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] value;
  logic        end_of_string;

  modport source (output valid, output value, output end_of_string, input ready);
  modport sink   (input valid, input value, input end_of_string, output ready);
endinterface

interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] unit;
  logic        has_data;
  logic        run_last;
  logic        string_done;

  modport source (output valid, output unit, output has_data, output run_last,
                  output string_done, input ready);
  modport sink   (input valid, input unit, input has_data, input run_last,
                  input string_done, output ready);
endinterface

// ===== rtl/utf8_utf16_bmp_transcoder_core.sv =====
// Top level of the UTF-8 / UTF-16 BMP transcoder with its configuration registers.
//
//   channel  | dir | handshake     | contents
//   ---------+-----+---------------+------------------------------------------
//   in_i     | in  | valid / ready | value, end_of_string
//   out_o    | out | valid / ready | unit, has_data, run_last, string_done
//   apb      | in  | psel/penable  | direction at 0x0, terminator at 0x4
//
// An accepted word sits in the input register; the result words it causes are
// moved one a cycle into the output register unless the output stalls. A word
// giving zero or one result does not hold the input, so a new word is taken every
// cycle unless the output stalls; an encoded two- or three-byte character holds
// the input until its last byte moves; the single output register sets the rate.
// Reset clears all control and stream state; a stalled output holds its word
// while the next input word is already taken.
`timescale 1ns / 1ps
module utf8_utf16_bmp_transcoder_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  u8u16_in_if.sink                            in_i,
  u8u16_out_if.source                         out_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [u8u16_pkg::PADDR_W-1:0]       paddr,
  input  logic [u8u16_pkg::PDATA_W-1:0]       pwdata,
  output logic [u8u16_pkg::PDATA_W-1:0]       prdata,
  output logic                                pready
);

  // Configuration registers.
  logic        dir_q;
  logic [15:0] term_q;

  // Stream state.
  u8u16_pkg::pend_e pend_q, pend_d;
  logic [7:0]       lead_q, lead_d;
  logic [7:0]       second_q, second_d;
  logic             stop_q, stop_d;

  // Input register.
  logic        s1_v_q;
  logic [15:0] s1_val_q;
  logic        s1_eos_q;
  logic [1:0]  idx_q;

  // Output register.
  logic                 out_v_q;
  u8u16_pkg::result_t   out_res_q;
  logic                 out_last_q;
  logic                 out_done_q;

  // Results of the held word.
  u8u16_pkg::result_t res [u8u16_pkg::MAX_RES];
  logic [1:0]         n_res;
  logic [7:0]         byte_in;
  logic               cfg_we;
  logic               out_free;
  logic               last_res;
  logic               s1_done;
  logic               in_ready;

  assign byte_in = s1_val_q[7:0];
  assign cfg_we  = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register read-back.
  always_comb begin
    if (paddr[2] == u8u16_pkg::REG_DIRECTION) begin
      prdata = {{(u8u16_pkg::PDATA_W-1){1'b0}}, dir_q};
    end else begin
      prdata = {{(u8u16_pkg::PDATA_W-16){1'b0}}, term_q};
    end
  end

  // Result words and next stream state for the held input word.
  always_comb begin
    pend_d   = pend_q;
    lead_d   = lead_q;
    second_d = second_q;
    stop_d   = stop_q;
    n_res    = 2'd0;
    for (int i = 0; i < u8u16_pkg::MAX_RES; i++) begin
      res[i] = '{unit: 16'h0000, has_data: 1'b1};
    end
    if (dir_q == u8u16_pkg::DIR_DECODE) begin
      case (pend_q)
        u8u16_pkg::PEND_TWO: begin
          res[0].unit = {5'b00000, lead_q[4:0], byte_in[5:0]};
          n_res       = 2'd1;
          pend_d      = u8u16_pkg::PEND_NONE;
        end
        u8u16_pkg::PEND_THREE: begin
          if (!s1_eos_q) begin
            second_d = byte_in;
            pend_d   = u8u16_pkg::PEND_SECOND;
          end else begin
            // Three-byte lead cut short: lead is replaced, this byte stands alone.
            res[0].unit = u8u16_pkg::REPL_CHAR;
            res[1].unit = byte_in[7] ? u8u16_pkg::REPL_CHAR : {8'h00, byte_in};
            n_res       = 2'd2;
            pend_d      = u8u16_pkg::PEND_NONE;
          end
        end
        u8u16_pkg::PEND_SECOND: begin
          res[0].unit = {lead_q[3:0], second_q[5:0], byte_in[5:0]};
          n_res       = 2'd1;
          pend_d      = u8u16_pkg::PEND_NONE;
        end
        default: begin
          if (byte_in[7:4] == u8u16_pkg::LEAD_THREE[7:4]) begin
            if (s1_eos_q) begin
              res[0].unit = u8u16_pkg::REPL_CHAR;
              n_res       = 2'd1;
            end else begin
              lead_d = byte_in;
              pend_d = u8u16_pkg::PEND_THREE;
            end
          end else if (byte_in[7:5] == u8u16_pkg::LEAD_TWO[7:5]) begin
            if (s1_eos_q) begin
              res[0].unit = u8u16_pkg::REPL_CHAR;
              n_res       = 2'd1;
            end else begin
              lead_d = byte_in;
              pend_d = u8u16_pkg::PEND_TWO;
            end
          end else if (!byte_in[7]) begin
            res[0].unit = {8'h00, byte_in};
            n_res       = 2'd1;
          end else begin
            res[0].unit = u8u16_pkg::REPL_CHAR;
            n_res       = 2'd1;
          end
        end
      endcase
    end else begin
      // Encode direction: the terminator silences output until the end of string.
      if (stop_q) begin
        n_res = 2'd0;
      end else if (s1_val_q == term_q) begin
        stop_d = 1'b1;
      end else if (s1_val_q == 16'h0000) begin
        n_res = 2'd0;
      end else if (s1_val_q < u8u16_pkg::ENC_TWO_MIN) begin
        res[0].unit = s1_val_q;
        n_res       = 2'd1;
      end else if (s1_val_q < u8u16_pkg::ENC_THR_MIN) begin
        res[0].unit = {8'h00, u8u16_pkg::LEAD_TWO | {3'b000, s1_val_q[10:6]}};
        res[1].unit = {8'h00, u8u16_pkg::CONT_MARK | {2'b00, s1_val_q[5:0]}};
        n_res       = 2'd2;
      end else begin
        res[0].unit = {8'h00, u8u16_pkg::LEAD_THREE | {4'h0, s1_val_q[15:12]}};
        res[1].unit = {8'h00, u8u16_pkg::CONT_MARK | {2'b00, s1_val_q[11:6]}};
        res[2].unit = {8'h00, u8u16_pkg::CONT_MARK | {2'b00, s1_val_q[5:0]}};
        n_res       = 2'd3;
      end
      if (s1_eos_q) begin
        stop_d = 1'b0;
        if (n_res == 2'd0) begin
          // Empty closing marker.
          res[0] = '{unit: 16'h0000, has_data: 1'b0};
          n_res  = 2'd1;
        end
      end
    end
  end

  // Handshake between the input register and the output register.
  assign out_free = !out_v_q || out_o.ready;
  assign last_res = (idx_q == n_res - 2'd1);
  assign s1_done  = s1_v_q && ((n_res == 2'd0) || (out_free && last_res));
  assign in_ready = !s1_v_q || s1_done;
  assign in_i.ready = in_ready;

  assign out_o.valid       = out_v_q;
  assign out_o.unit        = out_res_q.unit;
  assign out_o.has_data    = out_res_q.has_data;
  assign out_o.run_last    = out_last_q;
  assign out_o.string_done = out_done_q;

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q    <= u8u16_pkg::DIR_DECODE;
      term_q   <= 16'h0000;
      pend_q   <= u8u16_pkg::PEND_NONE;
      lead_q   <= 8'h00;
      second_q <= 8'h00;
      stop_q   <= 1'b0;
      s1_v_q   <= 1'b0;
      idx_q    <= 2'd0;
      out_v_q  <= 1'b0;
    end else begin
      if (cfg_we && (paddr[2] == u8u16_pkg::REG_DIRECTION)) begin
        // A direction write restarts the stream.
        dir_q    <= pwdata[0];
        pend_q   <= u8u16_pkg::PEND_NONE;
        lead_q   <= 8'h00;
        second_q <= 8'h00;
        stop_q   <= 1'b0;
      end else if (s1_done) begin
        pend_q   <= pend_d;
        lead_q   <= lead_d;
        second_q <= second_d;
        stop_q   <= stop_d;
      end
      if (cfg_we && (paddr[2] == u8u16_pkg::REG_TERMINATOR)) begin
        term_q <= pwdata[15:0];
      end

      if (in_ready) begin
        s1_v_q <= in_i.valid;
        idx_q  <= 2'd0;
      end else if (s1_v_q && (n_res != 2'd0) && out_free) begin
        idx_q <= idx_q + 2'd1;
      end

      if (s1_v_q && (n_res != 2'd0) && out_free) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      s1_val_q <= in_i.value;
      s1_eos_q <= in_i.end_of_string;
    end
    if (s1_v_q && (n_res != 2'd0) && out_free) begin
      out_res_q  <= res[idx_q];
      out_last_q <= last_res;
      out_done_q <= last_res && s1_eos_q;
    end
  end

  // The result index never runs past the last word of the held input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && (n_res != 2'd0)) |-> (idx_q < n_res))
    else $error("result index beyond result count");

  // An empty marker only closes a string.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_res_q.has_data) |-> (out_done_q && (out_res_q.unit == 16'h0000)))
    else $error("empty marker outside end of string");

  // The end of a string is always the last word of its input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_done_q) |-> out_last_q)
    else $error("string end without run end");

  // Decoding never gives an empty marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (dir_q == u8u16_pkg::DIR_DECODE)) |-> out_res_q.has_data)
    else $error("empty marker while decoding");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the UTF-8 / UTF-16 BMP transcoder core.
`timescale 1ns / 1ps
module tb_top;

  // One result word as seen on the output channel.
  typedef struct packed {
    logic [15:0] unit;
    logic        has_data;
    logic        run_last;
    logic        string_done;
  } out_word_t;

  logic clk_i;
  logic rst_ni;

  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [u8u16_pkg::PADDR_W-1:0] paddr;
  logic [u8u16_pkg::PDATA_W-1:0] pwdata;
  logic [u8u16_pkg::PDATA_W-1:0] prdata;
  logic                          pready;

  u8u16_in_if  in_if ();
  u8u16_out_if out_if ();

  utf8_utf16_bmp_transcoder_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Copy of the block's registers and stream state, kept by the predictor.
  logic               cfg_dir;
  logic [15:0]        cfg_term;
  logic [7:0]         held_lead;
  logic [7:0]         held_second;
  u8u16_pkg::pend_e   held_pend;
  logic               enc_stopped;

  // Words still due on the output channel, oldest first.
  out_word_t transcoded_q[$];

  int unsigned snd_idle_pct;
  int unsigned rcv_stall_pct;
  int unsigned fail_count;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on run time in case the block hangs.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic out_word_t mk_word(input logic [15:0] unit, input logic has_data);
    out_word_t w;
    w.unit        = unit;
    w.has_data    = has_data;
    w.run_last    = 1'b0;
    w.string_done = 1'b0;
    return w;
  endfunction

  // Works out the words that one accepted input word causes, and updates the state.
  task automatic transcode_word(input logic [15:0] v, input logic eos);
    out_word_t   words[$];
    logic [7:0]  b;
    b = v[7:0];
    if (cfg_dir == u8u16_pkg::DIR_DECODE) begin
      case (held_pend)
        u8u16_pkg::PEND_TWO: begin
          words = {words, mk_word({5'b0, held_lead[4:0], b[5:0]}, 1'b1)};
          held_pend = u8u16_pkg::PEND_NONE;
        end
        u8u16_pkg::PEND_THREE: begin
          if (!eos) begin
            held_second = b;
            held_pend   = u8u16_pkg::PEND_SECOND;
          end else begin
            // The lead is cut short; the last byte then stands on its own.
            words = {words, mk_word(u8u16_pkg::REPL_CHAR, 1'b1)};
            words = {words, mk_word((b < u8u16_pkg::CONT_MARK) ? {8'h00, b} :
                                    u8u16_pkg::REPL_CHAR, 1'b1)};
            held_pend = u8u16_pkg::PEND_NONE;
          end
        end
        u8u16_pkg::PEND_SECOND: begin
          words = {words, mk_word({held_lead[3:0], held_second[5:0], b[5:0]}, 1'b1)};
          held_pend = u8u16_pkg::PEND_NONE;
        end
        default: begin
          if ((b & 8'hF0) == u8u16_pkg::LEAD_THREE || (b & 8'hE0) == u8u16_pkg::LEAD_TWO) begin
            if (eos) begin
              words = {words, mk_word(u8u16_pkg::REPL_CHAR, 1'b1)};
            end else begin
              held_lead = b;
              held_pend = ((b & 8'hF0) == u8u16_pkg::LEAD_THREE) ? u8u16_pkg::PEND_THREE :
                                                                  u8u16_pkg::PEND_TWO;
            end
          end else if (b < u8u16_pkg::CONT_MARK) begin
            words = {words, mk_word({8'h00, b}, 1'b1)};
          end else begin
            words = {words, mk_word(u8u16_pkg::REPL_CHAR, 1'b1)};
          end
        end
      endcase
    end else begin
      if (!enc_stopped) begin
        if (v == cfg_term) begin
          enc_stopped = 1'b1;
        end else if (v != 16'h0000) begin
          if (v < u8u16_pkg::ENC_TWO_MIN) begin
            words = {words, mk_word(v, 1'b1)};
          end else if (v < u8u16_pkg::ENC_THR_MIN) begin
            words = {words, mk_word({8'h00, u8u16_pkg::LEAD_TWO | {3'b000, v[10:6]}}, 1'b1)};
            words = {words, mk_word({8'h00, u8u16_pkg::CONT_MARK | {2'b00, v[5:0]}}, 1'b1)};
          end else begin
            words = {words, mk_word({8'h00, u8u16_pkg::LEAD_THREE | {4'h0, v[15:12]}}, 1'b1)};
            words = {words, mk_word({8'h00, u8u16_pkg::CONT_MARK | {2'b00, v[11:6]}}, 1'b1)};
            words = {words, mk_word({8'h00, u8u16_pkg::CONT_MARK | {2'b00, v[5:0]}}, 1'b1)};
          end
        end
      end
      if (eos) begin
        enc_stopped = 1'b0;
        // A string that ends without bytes still gets an empty closing word.
        if (words.size() == 0) words = {words, mk_word(16'h0000, 1'b0)};
      end
    end
    if (words.size() != 0) begin
      words[words.size() - 1].run_last    = 1'b1;
      words[words.size() - 1].string_done = eos;
      foreach (words[i]) transcoded_q = {transcoded_q, words[i]};
    end
  endtask

  // Offers one word on the input channel and waits until it is taken.
  task automatic send_word(input logic [15:0] v, input logic eos);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle_pct);
    end
    in_if.valid         <= 1'b1;
    in_if.value         <= v;
    in_if.end_of_string <= eos;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    transcode_word(v, eos);
  endtask

  // Lowers valid and waits until every expected word has come out.
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (transcoded_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes one register over the configuration port while the block is idle.
  task automatic write_reg(input logic idx, input logic [u8u16_pkg::PDATA_W-1:0] data);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (idx == u8u16_pkg::REG_DIRECTION) begin
      cfg_dir     = data[0];
      held_lead   = 8'h00;
      held_second = 8'h00;
      held_pend   = u8u16_pkg::PEND_NONE;
      enc_stopped = 1'b0;
    end else begin
      cfg_term = data[15:0];
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result receiver: random stalls on ready.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // Result checker: each taken word against the oldest expectation.
  always @(posedge clk_i) begin
    out_word_t got;
    out_word_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got = {out_if.unit, out_if.has_data, out_if.run_last, out_if.string_done};
      if (transcoded_q.size() == 0) begin
        $display("%0t: unexpected word unit=%h has_data=%b run_last=%b string_done=%b",
                 $time, got.unit, got.has_data, got.run_last, got.string_done);
        fail_count++;
      end else begin
        want = transcoded_q.pop_front();
        if (got.unit !== want.unit || got.has_data !== want.has_data ||
            got.run_last !== want.run_last || got.string_done !== want.string_done) begin
          $display({"%0t: mismatch expected unit=%h hd=%b rl=%b sd=%b, ",
                    "got unit=%h hd=%b rl=%b sd=%b"},
                   $time, want.unit, want.has_data, want.run_last, want.string_done,
                   got.unit, got.has_data, got.run_last, got.string_done);
          fail_count++;
        end
      end
    end
  end

  // Extremes of the byte classes, lone leads and cut-short sequences.
  task automatic test_decode_directed();
    write_reg(u8u16_pkg::REG_DIRECTION, {31'b0, u8u16_pkg::DIR_DECODE});
    send_word(16'h0000, 1'b0);
    send_word(16'hAB7F, 1'b0);
    send_word(16'h00C2, 1'b0);
    send_word(16'hFFA9, 1'b0);
    send_word(16'h00EF, 1'b0);
    send_word(16'h00BF, 1'b0);
    send_word(16'h00BF, 1'b0);
    send_word(16'h0080, 1'b0);
    send_word(16'h00FF, 1'b0);
    send_word(16'h00C3, 1'b1);
    send_word(16'h00E4, 1'b0);
    send_word(16'h0041, 1'b1);
    send_word(16'h00E4, 1'b0);
    send_word(16'h0090, 1'b1);
  endtask

  // Each encoded length, surrogates, zero units and the terminator.
  task automatic test_encode_directed();
    write_reg(u8u16_pkg::REG_DIRECTION, {31'b0, u8u16_pkg::DIR_ENCODE});
    write_reg(u8u16_pkg::REG_TERMINATOR, 32'h0000_1234);
    send_word(16'h007F, 1'b0);
    send_word(16'h0080, 1'b0);
    send_word(16'h07FF, 1'b0);
    send_word(16'hD800, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'h1234, 1'b0);
    send_word(16'h0041, 1'b0);
    send_word(16'h0041, 1'b1);
    send_word(16'h0800, 1'b0);
    send_word(16'h0000, 1'b1);
  endtask

  // Random byte streams: mostly well-formed sequences, some noise and broken ones.
  task automatic test_decode_random(input int unsigned n_bytes);
    int unsigned sent;
    int unsigned kind;
    logic        eos;
    logic [7:0]  cont;
    write_reg(u8u16_pkg::REG_DIRECTION, {31'b0, u8u16_pkg::DIR_DECODE});
    sent = 0;
    while (sent < n_bytes) begin
      kind = $urandom_range(9);
      eos  = ($urandom_range(5) == 0);
      cont = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'h80 | 8'($urandom_range(63));
      case (kind)
        0, 1: begin
          send_word({8'($urandom_range(255)), 8'($urandom_range(127))}, eos);
          sent += 1;
        end
        2, 3, 4: begin
          send_word({8'($urandom_range(255)), u8u16_pkg::LEAD_TWO | 8'($urandom_range(31))},
                    1'b0);
          send_word({8'($urandom_range(255)), cont}, eos);
          sent += 2;
        end
        5, 6, 7: begin
          send_word({8'($urandom_range(255)), u8u16_pkg::LEAD_THREE | 8'($urandom_range(15))},
                    1'b0);
          send_word({8'($urandom_range(255)), 8'h80 | 8'($urandom_range(63))}, 1'b0);
          send_word({8'($urandom_range(255)), cont}, eos);
          sent += 3;
        end
        8: begin
          send_word(16'($urandom_range(65535)), ($urandom_range(3) == 0));
          sent += 1;
        end
        default: begin
          // A lead that meets the end of the string too early.
          if ($urandom_range(1) == 0) begin
            send_word({8'h00, u8u16_pkg::LEAD_THREE | 8'($urandom_range(15))}, 1'b0);
            send_word({8'($urandom_range(255)), 8'($urandom_range(255))}, 1'b1);
            sent += 2;
          end else begin
            send_word({8'h00, ($urandom_range(1) ? u8u16_pkg::LEAD_TWO : u8u16_pkg::LEAD_THREE) |
                       8'($urandom_range(15))}, 1'b1);
            sent += 1;
          end
        end
      endcase
    end
  endtask

  // Random code units of every encoded length, with zeros and terminators mixed in.
  task automatic test_encode_random(input int unsigned n_units, input logic [15:0] term);
    logic [15:0] v;
    write_reg(u8u16_pkg::REG_DIRECTION, {31'b0, u8u16_pkg::DIR_ENCODE});
    write_reg(u8u16_pkg::REG_TERMINATOR, {16'h0000, term});
    repeat (n_units) begin
      case ($urandom_range(9))
        0, 1:    v = 16'($urandom_range(16'h007F, 16'h0001));
        2, 3:    v = 16'($urandom_range(16'h07FF, 16'h0080));
        4, 5, 6: v = 16'($urandom_range(16'hFFFF, 16'h0800));
        7:       v = 16'h0000;
        8:       v = term;
        default: v = 16'($urandom_range(65535));
      endcase
      send_word(v, ($urandom_range(5) == 0));
    end
  endtask

  // Sets the idling of both sides for the next phase.
  task automatic set_idling(input int unsigned snd_pct, input int unsigned rcv_pct);
    settle();
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
  endtask

  // Test sequence.
  initial begin
    rst_ni              <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.value         <= 16'h0000;
    in_if.end_of_string <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    snd_idle_pct         = 0;
    rcv_stall_pct        = 0;
    fail_count           = 0;
    cfg_dir              = u8u16_pkg::DIR_DECODE;
    cfg_term             = 16'h0000;
    held_lead            = 8'h00;
    held_second          = 8'h00;
    held_pend            = u8u16_pkg::PEND_NONE;
    enc_stopped          = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_decode_directed();
    test_encode_directed();

    set_idling(0, 0);
    test_decode_random(40);
    test_encode_random(40, 16'h0000);

    set_idling(59, 0);
    test_decode_random(40);
    test_encode_random(40, 16'hFFFF);

    set_idling(0, 59);
    test_decode_random(40);
    test_encode_random(40, 16'($urandom_range(65535)));

    set_idling(36, 36);
    test_encode_random(40, 16'h0041);
    test_decode_random(40);

    settle();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/u8u16_pkg.sv
rtl/u8u16_if.sv
rtl/utf8_utf16_bmp_transcoder_core.sv
verif/tb_top.sv
